// ===== hdl/smfc_pkg.sv =====
// Package: types, register offsets and reset values for the SPI master FIFO controller.
package smfc_pkg;

  localparam int unsigned FifoDepthDefault = 128;

  // Action codes of an input item.
  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_XCHG  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Register byte offsets.
  localparam logic [9:0] OFF_GCR = 10'h004;
  localparam logic [9:0] OFF_TCR = 10'h008;
  localparam logic [9:0] OFF_IER = 10'h010;
  localparam logic [9:0] OFF_ISR = 10'h014;
  localparam logic [9:0] OFF_FCR = 10'h018;
  localparam logic [9:0] OFF_FSR = 10'h01c;
  localparam logic [9:0] OFF_WCR = 10'h020;
  localparam logic [9:0] OFF_CCR = 10'h024;
  localparam logic [9:0] OFF_MBR = 10'h030;
  localparam logic [9:0] OFF_MTC = 10'h034;
  localparam logic [9:0] OFF_BCC = 10'h038;
  localparam logic [9:0] OFF_DMA = 10'h088;
  localparam logic [9:0] OFF_TXD = 10'h200;
  localparam logic [9:0] OFF_RXD = 10'h300;

  // Reset values.
  localparam logic [31:0] RST_GCR = 32'h0000_0080;
  localparam logic [31:0] RST_TCR = 32'h0000_0087;
  localparam logic [31:0] RST_ISR = 32'h0000_0032;
  localparam logic [31:0] RST_FCR = 32'h0040_0001;
  localparam logic [31:0] RST_CCR = 32'h0000_0002;
  localparam logic [31:0] RST_DMA = 32'h0000_00a5;
  localparam logic [23:0] BURST_MASK = 24'hff_ffff;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // Latch the item's fields and start work.
    logic execute;  // Perform the decoded operation.
  } smfc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_mem;  // Item reads a FIFO store, which adds the ST_MEM state.
  } smfc_sts_t;

endpackage

// ===== hdl/smfc_ctrl.sv =====
// Controller state machine: sequences capture, execute and result handoff.
module smfc_ctrl
  import smfc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  output logic      m_tvalid_o,
  input  logic      m_tready_i,
  input  smfc_sts_t sts_i,
  output smfc_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_MEM  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Accept only when no result is held.
  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = (state_q == ST_OUT);
  assign cmd_o.capture = s_tready_o && s_tvalid_i;
  assign cmd_o.execute = (state_q == ST_EXEC);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_tvalid_i) state_d = ST_EXEC;
      ST_EXEC: state_d = sts_i.needs_mem ? ST_MEM : ST_OUT;
      ST_MEM:  state_d = ST_OUT;
      ST_OUT:  if (m_tready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/smfc_datapath.sv =====
// Datapath: register file, TX and RX FIFO stores and result assembly.
module smfc_datapath
  import smfc_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  smfc_cmd_t   cmd_i,
  output smfc_sts_t   sts_o,
  input  logic [1:0]  action_i,
  input  logic [9:0]  offset_i,
  input  logic [31:0] write_data_i,
  input  logic [31:0] slave_word_i,
  output logic [31:0] read_data_o,
  output logic [31:0] shifted_word_o,
  output logic        shift_valid_o,
  output logic [7:0]  burst_left_o
);

  localparam int unsigned AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [7:0] DEPTH8 = 8'(FIFO_DEPTH);

  // Captured item.
  logic [1:0]  act_q;
  logic [9:0]  off_q;
  logic [31:0] wd_q, sw_q;

  // Registers.
  logic [31:0] gcr_q, tcr_q, ier_q, isr_q, fcr_q, wcr_q, ccr_q;
  logic [31:0] mbr_q, mtc_q, bcc_q, dma_q;
  logic [AW-1:0] tx_head_q, rx_head_q;
  logic [7:0] tx_fill_q, rx_fill_q, pend_q;

  // FIFO stores.
  logic [31:0] tx_mem [FIFO_DEPTH];
  logic [31:0] rx_mem [FIFO_DEPTH];
  logic [31:0] tx_rd_q, rx_rd_q;

  // Result registers.
  logic [31:0] rd_q, sh_q;
  logic        sv_q, sel_tx_q, sel_rx_q;

  logic is_read, is_write, is_xchg;
  logic rx_pop, tx_push, tx_pop, rx_push;
  logic [AW-1:0] tx_wa, rx_wa;
  logic [23:0] burst_n;

  assign is_read  = cmd_i.execute && (action_e'(act_q) == ACT_READ);
  assign is_write = cmd_i.execute && (action_e'(act_q) == ACT_WRITE);
  assign is_xchg  = cmd_i.execute && (action_e'(act_q) == ACT_XCHG) && (pend_q != 8'd0);
  assign rx_pop   = is_read && (off_q == OFF_RXD) && (rx_fill_q != 8'd0);
  assign tx_push  = is_write && (off_q == OFF_TXD) && (tx_fill_q < DEPTH8);
  assign tx_pop   = is_xchg && (tx_fill_q != 8'd0);
  assign rx_push  = is_xchg && (rx_fill_q < DEPTH8);
  assign sts_o.needs_mem = rx_pop || tx_pop;
  assign burst_n = mbr_q[23:0] & BURST_MASK;

  // Circular write addresses, wrapped without a divider.
  always_comb begin
    logic [8:0] tsum, rsum;
    tsum = 9'(tx_head_q) + 9'(tx_fill_q);
    rsum = 9'(rx_head_q) + 9'(rx_fill_q);
    if (tsum >= 9'(FIFO_DEPTH)) tsum = tsum - 9'(FIFO_DEPTH);
    if (rsum >= 9'(FIFO_DEPTH)) rsum = rsum - 9'(FIFO_DEPTH);
    tx_wa = tsum[AW-1:0];
    rx_wa = rsum[AW-1:0];
  end

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    r = (32'(p) == FIFO_DEPTH - 1) ? '0 : p + AW'(1);
    return r;
  endfunction

  // Memories: one write and one registered read per store. The head word is
  // read as the item executes and then held until the next item executes.
  always_ff @(posedge clk_i) begin
    if (tx_push) tx_mem[tx_wa] <= wd_q;
    if (rx_push) rx_mem[rx_wa] <= sw_q;
    if (cmd_i.execute) begin
      tx_rd_q <= tx_mem[tx_head_q];
      rx_rd_q <= rx_mem[rx_head_q];
    end
  end

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= action_i;
      off_q <= offset_i;
      wd_q  <= write_data_i;
      sw_q  <= slave_word_i;
    end
  end

  // Register file and FIFO pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gcr_q <= RST_GCR; tcr_q <= RST_TCR; ier_q <= '0; isr_q <= RST_ISR;
      fcr_q <= RST_FCR; wcr_q <= '0; ccr_q <= RST_CCR; mbr_q <= '0;
      mtc_q <= '0; bcc_q <= '0; dma_q <= RST_DMA;
      tx_head_q <= '0; rx_head_q <= '0;
      tx_fill_q <= '0; rx_fill_q <= '0; pend_q <= '0;
      rd_q <= '0; sh_q <= '0; sv_q <= 1'b0; sel_tx_q <= 1'b0; sel_rx_q <= 1'b0;
    end else if (cmd_i.execute) begin
      rd_q <= '0; sh_q <= '0; sv_q <= 1'b0;
      sel_tx_q <= tx_pop;
      sel_rx_q <= rx_pop;
      if (is_read) begin
        unique case (off_q)
          OFF_GCR: rd_q <= gcr_q;
          OFF_TCR: rd_q <= tcr_q;
          OFF_IER: rd_q <= ier_q;
          OFF_ISR: rd_q <= isr_q;
          OFF_FCR: rd_q <= fcr_q;
          OFF_FSR: rd_q <= {8'd0, tx_fill_q, 8'd0, rx_fill_q};
          OFF_WCR: rd_q <= wcr_q;
          OFF_CCR: rd_q <= ccr_q;
          OFF_MBR: rd_q <= mbr_q;
          OFF_MTC: rd_q <= mtc_q;
          OFF_BCC: rd_q <= bcc_q;
          OFF_DMA: rd_q <= dma_q;
          default: rd_q <= '0;
        endcase
        if (rx_pop) begin
          rx_head_q <= next_ptr(rx_head_q);
          rx_fill_q <= rx_fill_q - 8'd1;
        end
      end
      if (is_write) begin
        unique case (off_q)
          OFF_GCR: gcr_q <= wd_q;
          OFF_TCR: begin
            if (wd_q[31] && (burst_n != 24'd0)) pend_q <= tx_fill_q;
            tcr_q <= {1'b0, wd_q[30:0]};
          end
          OFF_IER: ier_q <= wd_q;
          OFF_ISR: isr_q <= wd_q;
          OFF_FCR: begin
            if (wd_q[31]) begin
              tx_head_q <= '0;
              tx_fill_q <= '0;
              fcr_q <= {1'b0, wd_q[30:0]};
            end else if (wd_q[15]) begin
              rx_head_q <= '0;
              rx_fill_q <= '0;
              fcr_q <= {wd_q[31:16], 1'b0, wd_q[14:0]};
            end else begin
              fcr_q <= wd_q;
            end
          end
          OFF_WCR: wcr_q <= wd_q;
          OFF_CCR: ccr_q <= wd_q;
          OFF_MBR: mbr_q <= wd_q;
          OFF_MTC: mtc_q <= wd_q;
          OFF_BCC: bcc_q <= wd_q;
          OFF_DMA: dma_q <= wd_q;
          OFF_TXD: if (tx_push) tx_fill_q <= tx_fill_q + 8'd1;
          default: ;
        endcase
      end
      if (is_xchg) begin
        sv_q   <= 1'b1;
        pend_q <= pend_q - 8'd1;
        if (tx_pop) begin
          tx_head_q <= next_ptr(tx_head_q);
          tx_fill_q <= tx_fill_q - 8'd1;
        end
        if (rx_push) rx_fill_q <= rx_fill_q + 8'd1;
      end
    end
  end

  // Popped words come from the registered memory read.
  assign read_data_o    = sel_rx_q ? rx_rd_q : rd_q;
  assign shifted_word_o = sel_tx_q ? tx_rd_q : sh_q;
  assign shift_valid_o  = sv_q;
  assign burst_left_o   = pend_q;

endmodule

// ===== hdl/spi_master_fifo_controller_unit.sv =====
// Top level of the SPI master register block with TX and RX word FIFOs.
//
//  Channel   Direction  Handshake          Payload
//  s_axis    in         s_tvalid/s_tready  action, offset, write_data, slave_word
//  m_axis    out        m_tvalid/m_tready  read_data, shifted_word, shift_valid, burst_left
//
// An accepted item passes through ST_EXEC, then ST_MEM when it pops a FIFO word, since
// the pop needs the registered store read, and then ST_OUT, which offers its result.
// Input is taken again in the cycle after the result is handed off, so the block
// takes no new item while one is in progress.
// Reset returns the register file to its reset values and empties both FIFOs.
// A stalled output holds its result and blocks further input.
module spi_master_fifo_controller_unit
  import smfc_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FifoDepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [79:0]  s_tdata_i,   // action[1:0], offset[11:2], write_data[43:12], slave_word[75:44]
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [79:0]  m_tdata_o    // read_data[31:0], shifted_word[63:32], shift_valid[64], burst_left[72:65]
);

  smfc_cmd_t cmd;
  smfc_sts_t sts;
  logic [31:0] rd, sh;
  logic        sv;
  logic [7:0]  bl;

  smfc_ctrl u_ctrl (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o, .m_tvalid_o, .m_tready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  smfc_datapath #(.FIFO_DEPTH(FIFO_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .action_i(s_tdata_i[1:0]), .offset_i(s_tdata_i[11:2]),
    .write_data_i(s_tdata_i[43:12]), .slave_word_i(s_tdata_i[75:44]),
    .read_data_o(rd), .shifted_word_o(sh), .shift_valid_o(sv), .burst_left_o(bl)
  );

  assign m_tdata_o = {7'd0, bl, sv, sh, rd};

endmodule
